### src/stereo_linear_downsampler_top_macros.svh
// Assertion macros shared by the stereo linear downsampler modules.
// Included by the module files that carry concurrent checks; no other dependencies.
`ifndef STEREO_LINEAR_DOWNSAMPLER_TOP_MACROS_SVH
`define STEREO_LINEAR_DOWNSAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sld check failed");

// Next-cycle implication, disabled during reset.
`define SLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sld check failed");

`endif

### src/sld_pkg.sv
// Package for the stereo linear downsampler: widths, reset constants and the
// stage record passed from the phase tracker to the interpolator. No dependencies.
package sld_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 16;
   localparam int STEP_W   = 18;
   localparam int SKIP_W   = 2;
   localparam int CARRY_W  = 3;

   localparam logic [PHASE_W:0]  ONE_Q16    = 17'h10000;
   localparam logic [STEP_W-1:0] STEP_RESET = 18'h10000;

   // One sample pair with its neighbor and the phase between them.
   typedef struct packed {
      logic [SAMPLE_W-1:0] prev_left;
      logic [SAMPLE_W-1:0] prev_right;
      logic [SAMPLE_W-1:0] cur_left;
      logic [SAMPLE_W-1:0] cur_right;
      logic [PHASE_W-1:0]  phase;
   } sld_stage_type;

endpackage

### src/stereo_linear_downsampler_top.sv
// Stereo linear downsampler: one source pair per item in, zero or one result out.
// An emitting input item reaches rsp_tvalid through the stage register, then the result register.
// One input item per cycle unless rsp_tready stalls; skipped items are taken in, give no result.
// The result register is refilled in the cycle it is taken, so back-to-back flow is sustained.
// Reset (synchronous, active high): step = 1.0, phase, skip count and previous sample zero,
// both stages empty.
`include "stereo_linear_downsampler_top_macros.svh"
module stereo_linear_downsampler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [sld_pkg::STEP_W-1:0]     csr_wr_data,  // phase_step
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*sld_pkg::SAMPLE_W-1:0] req_tdata,    // [15:0] src_left, [31:16] src_right
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [2*sld_pkg::SAMPLE_W-1:0] rsp_tdata     // [15:0] out_left, [31:16] out_right
);
   import sld_pkg::*;

   logic                accept;
   logic                advance;
   logic                stage_valid;
   sld_stage_type       stage;
   logic [SAMPLE_W-1:0] lerp_left;
   logic [SAMPLE_W-1:0] lerp_right;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_left_ff, out_left_in;
   logic [SAMPLE_W-1:0] out_right_ff, out_right_in;

   // Advance the stage when the result register is empty or being taken.
   assign advance    = stage_valid && (!out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid || advance;
   assign accept     = req_tvalid && req_tready;

   sld_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .src_left    (req_tdata[SAMPLE_W-1:0]),
      .src_right   (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   sld_lerp u_lerp_left (
      .phase       (stage.phase),
      .prev_sample (stage.prev_left),
      .cur_sample  (stage.cur_left),
      .out_sample  (lerp_left)
   );

   sld_lerp u_lerp_right (
      .phase       (stage.phase),
      .prev_sample (stage.prev_right),
      .cur_sample  (stage.cur_right),
      .out_sample  (lerp_right)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_left_in  = lerp_left;
         out_right_in = lerp_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_right_ff, out_left_ff};

   `SLD_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_valid_ff)
   `SLD_ASSERT_NEXT(a_stalled_stage_holds, clock, reset, stage_valid && !advance, stage_valid)
   `SLD_ASSERT_NOW(a_ready_when_stage_empty, clock, reset, !stage_valid, req_tready)

endmodule

### src/sld_lerp.sv
// One channel of the linear interpolator: two weighted products and their sum.
// Depends on sld_pkg.
module sld_lerp (
   input  logic [sld_pkg::PHASE_W-1:0]         phase,
   input  logic signed [sld_pkg::SAMPLE_W-1:0] prev_sample,
   input  logic signed [sld_pkg::SAMPLE_W-1:0] cur_sample,
   output logic signed [sld_pkg::SAMPLE_W-1:0] out_sample
);
   import sld_pkg::*;

   logic [PHASE_W:0]          weight_prev;
   logic signed [PHASE_W+1:0] weight_prev_s;
   logic signed [PHASE_W+1:0] weight_cur_s;
   logic signed [33:0]        prod_prev;
   logic signed [33:0]        prod_cur;

   assign weight_prev   = ONE_Q16 - {1'b0, phase};
   assign weight_prev_s = $signed({1'b0, weight_prev});
   assign weight_cur_s  = $signed({2'b00, phase});
   assign prod_prev     = weight_prev_s * prev_sample;
   assign prod_cur      = weight_cur_s * cur_sample;

   // Bits 31:16 are the floored quotient by 65536 modulo 2^16.
   assign out_sample = prod_prev[31:16] + prod_cur[31:16];

endmodule

### src/sld_phase.sv
// Phase tracker: step register, previous sample, fractional phase, skip count
// and the stage register feeding the interpolator. Depends on sld_pkg and the macros.
`include "stereo_linear_downsampler_top_macros.svh"
module sld_phase (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [sld_pkg::STEP_W-1:0]   csr_wr_data,
   input  logic                         accept,
   input  logic [sld_pkg::SAMPLE_W-1:0] src_left,
   input  logic [sld_pkg::SAMPLE_W-1:0] src_right,
   input  logic                         advance,
   output logic                         stage_valid,
   output sld_pkg::sld_stage_type       stage
);
   import sld_pkg::*;

   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [SAMPLE_W-1:0] prev_left_ff, prev_left_in;
   logic [SAMPLE_W-1:0] prev_right_ff, prev_right_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic                stage_valid_ff, stage_valid_in;
   sld_stage_type       stage_ff, stage_in;
   logic                emit;
   logic [STEP_W:0]     phase_sum;
   logic [CARRY_W-1:0]  carry;

   assign emit      = accept && (skip_ff == '0);
   assign phase_sum = {3'b000, phase_ff} + {1'b0, step_ff};
   assign carry     = phase_sum[STEP_W:PHASE_W];

   always_comb begin
      step_in        = csr_wr_en ? csr_wr_data : step_ff;
      prev_left_in   = prev_left_ff;
      prev_right_in  = prev_right_ff;
      phase_in       = phase_ff;
      skip_in        = skip_ff;
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff && !advance;
      if (accept) begin
         prev_left_in  = src_left;
         prev_right_in = src_right;
      end
      if (emit) begin
         stage_in.prev_left  = prev_left_ff;
         stage_in.prev_right = prev_right_ff;
         stage_in.cur_left   = src_left;
         stage_in.cur_right  = src_right;
         stage_in.phase      = phase_ff;
         stage_valid_in      = 1'b1;
         phase_in            = phase_sum[PHASE_W-1:0];
         // carry of zero means phase plus step stays below one: no skip
         skip_in = (carry == '0) ? '0 : SKIP_W'(carry - CARRY_W'(1));
      end else if (accept) begin
         skip_in = skip_ff - SKIP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= STEP_RESET;
         prev_left_ff   <= '0;
         prev_right_ff  <= '0;
         phase_ff       <= '0;
         skip_ff        <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         step_ff        <= step_in;
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         phase_ff       <= phase_in;
         skip_ff        <= skip_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   `SLD_ASSERT_NEXT(a_skip_counts_down, clock, reset, accept && (skip_ff != '0), skip_ff == $past(skip_ff) - SKIP_W'(1))
   `SLD_ASSERT_NEXT(a_skip_no_stage, clock, reset, accept && (skip_ff != '0) && !stage_valid_ff, !stage_valid_ff)
   `SLD_ASSERT_NEXT(a_step_written, clock, reset, csr_wr_en, step_ff == $past(csr_wr_data))

endmodule

### dv/stereo_linear_downsampler_top_tb.sv
// Self-checking testbench for stereo_linear_downsampler_top: random and directed stereo
// items, a cycle-free predictor of the interpolation and skip logic, and a result checker.
// Depends on sld_pkg and the top module only.
module stereo_linear_downsampler_top_tb;

   import sld_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 50;

   typedef struct {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } sample_pair_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [STEP_W-1:0]       csr_wr_data = '0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [2*SAMPLE_W-1:0]   req_tdata   = '0;  // [15:0] src_left, [31:16] src_right
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [2*SAMPLE_W-1:0]   rsp_tdata;         // [15:0] out_left, [31:16] out_right

   stereo_linear_downsampler_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   // Predicted block state
   logic [SAMPLE_W-1:0] prev_left_q;
   logic [SAMPLE_W-1:0] prev_right_q;
   logic [PHASE_W-1:0]  phase_q;
   logic [SKIP_W-1:0]   skip_left_q;
   logic [STEP_W-1:0]   step_q;

   logic [2*SAMPLE_W-1:0] pending_items[$];
   sample_pair_type       expected_pairs[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  req_took      = 0;
   bit  hold_request  = 0;
   int  hold_left     = 0;
   int  mismatches    = 0;
   int  items_taken   = 0;
   int  results_seen  = 0;
   int  step_writes   = 0;
   int  stall_cycles  = 0;

   // floor(((1 - phase) * prev + phase * cur)) per term, low 16 bits of the sum
   function automatic logic [SAMPLE_W-1:0] blend_sample(input logic [SAMPLE_W-1:0] prev,
                                                        input logic [SAMPLE_W-1:0] cur,
                                                        input logic [PHASE_W-1:0]  ph);
      longint signed w_prev;
      longint signed w_cur;
      longint signed total;
      w_prev = 65536 - longint'(ph);
      w_cur  = longint'(ph);
      total  = ((w_prev * longint'($signed(prev))) >>> 16)
             + ((w_cur * longint'($signed(cur))) >>> 16);
      return total[SAMPLE_W-1:0];
   endfunction

   task automatic reset_model();
      prev_left_q  = '0;
      prev_right_q = '0;
      phase_q      = '0;
      skip_left_q  = '0;
      step_q       = STEP_RESET;
   endtask

   task automatic downsample_take(input logic [2*SAMPLE_W-1:0] data);
      logic [SAMPLE_W-1:0] cur_l;
      logic [SAMPLE_W-1:0] cur_r;
      sample_pair_type     pair;
      int unsigned         sum;
      int unsigned         carry;
      cur_l = data[SAMPLE_W-1:0];
      cur_r = data[2*SAMPLE_W-1:SAMPLE_W];
      if (skip_left_q != 0) begin
         // skipped item: load as previous only
         skip_left_q = skip_left_q - 1'b1;
      end else begin
         pair.left  = blend_sample(prev_left_q, cur_l, phase_q);
         pair.right = blend_sample(prev_right_q, cur_r, phase_q);
         expected_pairs.push_back(pair);
         sum         = int'(phase_q) + int'(step_q);
         carry       = sum >> 16;
         phase_q     = sum[PHASE_W-1:0];
         skip_left_q = (carry > 0) ? SKIP_W'((carry - 1) & 3) : '0;
      end
      prev_left_q  = cur_l;
      prev_right_q = cur_r;
   endtask

   task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                  input logic [SAMPLE_W-1:0] got);
      $display("MISMATCH %s: expected %h got %h (result %0d)", what, want, got, results_seen);
      mismatches++;
   endtask

   // Monitor: check results against the oldest expectation, then predict accepted items
   always @(posedge clock) begin
      sample_pair_type want;
      if (reset) begin
         reset_model();
         req_took = 0;
      end else begin
         if (csr_wr_en)
            step_q = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_pairs.size() == 0) begin
               report_mismatch("result with nothing expected", '0, rsp_tdata[SAMPLE_W-1:0]);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want.left)
                  report_mismatch("out_left", want.left, rsp_tdata[SAMPLE_W-1:0]);
               if (rsp_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right)
                  report_mismatch("out_right", want.right, rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            end
         end
         req_took = req_tvalid && req_tready;
         if (req_took) begin
            items_taken++;
            downsample_take(req_tdata);
         end
      end
   end

   // Driver: offer the next pending item once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_items.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                        stall_cycles, expected_pairs.size());
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

   task automatic queue_item(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
      pending_items.push_back({right, left});
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] corners[5];
      corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
      if ($urandom_range(7) == 0)
         return corners[$urandom_range(4)];
      return SAMPLE_W'($urandom);
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_pairs.size() != 0)
         @(posedge clock);
      // skipped items give no result; let the pipeline empty before touching the step
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      step_writes++;
   endtask

   initial begin
      logic [STEP_W-1:0] steps[RANDOM_PHASES];
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 65;

      // unit step: corner samples, every item gives a result
      write_step(STEP_RESET);
      queue_item(16'h0000, 16'h0000);
      queue_item(16'h7fff, 16'h8000);
      queue_item(16'h8000, 16'h7fff);
      queue_item(16'h7fff, 16'h7fff);
      queue_item(16'h8000, 16'h8000);
      queue_item(16'hffff, 16'h0001);
      queue_item(16'h5555, 16'haaaa);
      queue_item(16'h0000, 16'h0000);
      wait_drained();

      // maximum step: three skipped items after most results
      write_step({STEP_W{1'b1}});
      for (int i = 0; i < 8; i++)
         queue_item(i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'h7fff : 16'h8000);
      wait_drained();

      // step below one: fractional phase, carries only now and then
      write_step(STEP_W'(18'h08000));
      queue_item(16'h7fff, 16'h8000);
      queue_item(16'h8000, 16'h7fff);
      queue_item(16'h8000, 16'h8000);
      queue_item(16'h7fff, 16'h7fff);
      queue_item(16'h1234, 16'hedcb);
      queue_item(16'hffff, 16'h0000);
      wait_drained();

      steps[0] = STEP_RESET;
      steps[1] = {STEP_W{1'b1}};
      steps[2] = '0;
      steps[3] = STEP_W'($urandom_range(65536, 262143));
      steps[4] = STEP_W'(18'h18000);
      steps[5] = STEP_W'($urandom_range(0, 65535));
      steps[6] = STEP_W'(18'h2aaab);
      steps[7] = STEP_W'($urandom_range(65536, 262143));
      steps[8] = STEP_W'(18'h20000);
      steps[9] = STEP_W'($urandom_range(65536, 262143));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 4) begin
            send_idle_pct = 23;
            recv_idle_pct = 65;
         end else if (p < 7) begin
            send_idle_pct = 65;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_step(steps[p]);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_item(random_sample(), random_sample());
         if (p == 7) begin
            // hold the receiver while the sender keeps offering, to back up the pipeline
            @(posedge clock);
            hold_request = 1;
         end
         wait_drained();
      end

      $display("Run covered %0d source items and %0d checked results over %0d step settings,",
               items_taken, results_seen, step_writes);
      $display("including zero, fractional, unit and maximum steps and a long output hold-off.");
      if (mismatches == 0 && expected_pairs.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
